FILE: rtl/core/bmrd_pkg.sv
// Shared types and constants of the byte mismatch run detector.
`timescale 1ns / 1ps
package bmrd_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int LIMIT_W = 13;
	localparam int POS_W = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_MODULE_BASE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SECTION_OFFSET = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIT_LIMIT = 2'd2;

	localparam logic [LIMIT_W-1:0] HIT_LIMIT_RESET = 13'd4096;
	localparam logic [POS_W-1:0] RUN_COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [63:0] module_base;
		logic [31:0] section_offset;
		logic [LIMIT_W-1:0] hit_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0] hit_rva;
		logic [63:0] hit_address;
		logic [7:0] live_first;
		logic [7:0] reference_first;
		logic [31:0] run_length;
	} hit_t;

endpackage

FILE: rtl/core/bmrd_run_tracker.sv
// Mismatch run state, hit counting and hit formation for one byte pair per step.
`timescale 1ns / 1ps
module bmrd_run_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      ref_byte,
	input  logic [7:0]      live_byte,
	input  logic            last,
	input  bmrd_pkg::cfg_t  cfg,
	output logic            hit_fire,
	output bmrd_pkg::hit_t  hit
);
	import bmrd_pkg::*;

	logic               in_run_q;
	logic [POS_W-1:0]   position_q;
	logic [POS_W-1:0]   run_start_q;
	logic [POS_W-1:0]   run_count_q;
	logic [7:0]         first_live_q;
	logic [7:0]         first_ref_q;
	logic [LIMIT_W-1:0] hits_q;

	logic               mismatch;
	logic               close_run;
	logic [POS_W-1:0]   run_start_d;
	logic [POS_W-1:0]   run_count_d;
	logic [7:0]         first_live_d;
	logic [7:0]         first_ref_d;
	logic [31:0]        rva;

	always_comb begin
		mismatch = ref_byte != live_byte;
		run_start_d = run_start_q;
		run_count_d = run_count_q;
		first_live_d = first_live_q;
		first_ref_d = first_ref_q;
		if (mismatch) begin
			if (!in_run_q) begin
				run_start_d = position_q;
				run_count_d = 32'd1;
				first_live_d = live_byte;
				first_ref_d = ref_byte;
			end else if (run_count_q != RUN_COUNT_MAX) begin
				run_count_d = run_count_q + 32'd1;
			end
		end
		close_run = mismatch ? last : in_run_q;
		hit_fire = close_run && (hits_q < cfg.hit_limit);
		rva = cfg.section_offset + run_start_d;
		hit.hit_rva = rva;
		hit.hit_address = cfg.module_base + {32'd0, rva};
		hit.live_first = first_live_d;
		hit.reference_first = first_ref_d;
		hit.run_length = run_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			position_q <= '0;
			run_start_q <= '0;
			run_count_q <= '0;
			first_live_q <= '0;
			first_ref_q <= '0;
			hits_q <= '0;
		end else if (step) begin
			in_run_q <= mismatch && !last;
			position_q <= last ? '0 : position_q + 32'd1;
			run_start_q <= run_start_d;
			run_count_q <= run_count_d;
			first_live_q <= first_live_d;
			first_ref_q <= first_ref_d;
			if (step && hit_fire) begin
				hits_q <= hits_q + 13'd1;
			end
		end
	end

endmodule

FILE: rtl/core/byte_mismatch_run_detector_unit.sv
// Top level of the byte mismatch run detector: config registers, input and result registers.
//
// Channel  Direction  Handshake            Word
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_ready    reference_byte, live_byte, section_end
// out      out        out_valid/out_ready  hit_rva, hit_address, live_first,
//                                          reference_first, run_length
//
// One byte pair is accepted per cycle unless the output stalls; the hit is registered.
// The rate is set by the input register feeding one compare and add stage into the result
// register. Reset clears the run state, hit count and config registers (hit limit to 4096).
// A stalled result holds the pipe, and the input register still takes one word behind it.
// The config port is always ready.
`timescale 1ns / 1ps
module byte_mismatch_run_detector_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bmrd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       reference_byte,
	input  logic [7:0]                       live_byte,
	input  logic                             section_end,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [31:0]                      hit_rva,
	output logic [63:0]                      hit_address,
	output logic [7:0]                       live_first,
	output logic [7:0]                       reference_first,
	output logic [31:0]                      run_length
);
	import bmrd_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] ref_s1;
	logic [7:0] live_s1;
	logic       end_s1;
	logic       out_valid_q;
	hit_t       hit_q;
	logic       advance;
	logic       hit_fire;
	hit_t       hit;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.module_base <= '0;
			cfg_q.section_offset <= '0;
			cfg_q.hit_limit <= HIT_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODULE_BASE: cfg_q.module_base <= cfg_data;
				CFG_SECTION_OFFSET: cfg_q.section_offset <= cfg_data[31:0];
				CFG_HIT_LIMIT: cfg_q.hit_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ref_s1 <= reference_byte;
			live_s1 <= live_byte;
			end_s1 <= section_end;
		end
	end

	bmrd_run_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.ref_byte  (ref_s1),
		.live_byte (live_s1),
		.last      (end_s1),
		.cfg       (cfg_q),
		.hit_fire  (hit_fire),
		.hit       (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && hit_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && hit_fire) begin
			hit_q <= hit;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_rva = hit_q.hit_rva;
	assign hit_address = hit_q.hit_address;
	assign live_first = hit_q.live_first;
	assign reference_first = hit_q.reference_first;
	assign run_length = hit_q.run_length;

endmodule

FILE: dv/tb_byte_mismatch_run_detector_unit.sv
// Self-checking testbench of the byte mismatch run detector: directed and random byte streams.
`timescale 1ns / 1ps
module tb_byte_mismatch_run_detector_unit;
	import bmrd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE = 8;
	localparam int unsigned RANDOM_PAIRS = 160;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [63:0]            cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             reference_byte;
	logic [7:0]             live_byte;
	logic                   section_end;
	logic                   out_valid;
	logic                   out_ready;
	logic [31:0]            hit_rva;
	logic [63:0]            hit_address;
	logic [7:0]             live_first;
	logic [7:0]             reference_first;
	logic [31:0]            run_length;

	// Predicted register copies and run state.
	logic [63:0]        base_addr = '0;
	logic [31:0]        sect_rva = '0;
	logic [LIMIT_W-1:0] limit_cfg = HIT_LIMIT_RESET;
	logic               run_open = 1'b0;
	logic [31:0]        byte_pos = '0;
	logic [31:0]        run_origin = '0;
	logic [31:0]        run_len = '0;
	logic [7:0]         origin_live = '0;
	logic [7:0]         origin_ref = '0;
	logic [LIMIT_W-1:0] hits_sent = '0;

	hit_t expected_hits[$];
	int unsigned mismatches = 0;
	int unsigned hits_checked = 0;
	int unsigned pairs_accepted = 0;
	int unsigned reg_writes = 0;
	bit quiet = 1'b0;

	byte_mismatch_run_detector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.reference_byte(reference_byte),
		.live_byte(live_byte),
		.section_end(section_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit_rva(hit_rva),
		.hit_address(hit_address),
		.live_first(live_first),
		.reference_first(reference_first),
		.run_length(run_length)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic int unsigned pick_stall();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// A run closes on an equal byte or at the section end; closed runs past the limit are dropped.
	function automatic void track_mismatch_run(input logic [7:0] ref_b, input logic [7:0] live_b,
		input logic last);
		logic closing;
		logic [31:0] rva;
		hit_t h;
		closing = 1'b0;
		if (ref_b != live_b) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_origin = byte_pos;
				run_len = 32'd1;
				origin_live = live_b;
				origin_ref = ref_b;
			end else if (run_len != RUN_COUNT_MAX) begin
				run_len = run_len + 32'd1;
			end
			closing = last;
		end else begin
			closing = run_open;
		end
		if (closing) begin
			run_open = 1'b0;
			if (hits_sent < limit_cfg) begin
				hits_sent = hits_sent + 1'b1;
				rva = sect_rva + run_origin;
				h.hit_rva = rva;
				h.hit_address = base_addr + {32'd0, rva};
				h.live_first = origin_live;
				h.reference_first = origin_ref;
				h.run_length = run_len;
				expected_hits.insert(expected_hits.size(), h);
			end
		end
		if (last) begin
			run_open = 1'b0;
			byte_pos = '0;
		end else begin
			byte_pos = byte_pos + 32'd1;
		end
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("hit %0d %s: expected %h, got %h", hits_checked, what, want, got);
		end
	endfunction

	function automatic void check_hit();
		hit_t h;
		if (expected_hits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected hit: rva %h address %h length %0d", hit_rva, hit_address,
					run_length);
			return;
		end
		h = expected_hits.pop_front();
		check_field("hit_rva", {32'd0, h.hit_rva}, {32'd0, hit_rva});
		check_field("hit_address", h.hit_address, hit_address);
		check_field("live_first", {56'd0, h.live_first}, {56'd0, live_first});
		check_field("reference_first", {56'd0, h.reference_first}, {56'd0, reference_first});
		check_field("run_length", {32'd0, h.run_length}, {32'd0, run_length});
		hits_checked++;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					CFG_MODULE_BASE: base_addr = cfg_data;
					CFG_SECTION_OFFSET: sect_rva = cfg_data[31:0];
					CFG_HIT_LIMIT: limit_cfg = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pairs_accepted++;
				track_mismatch_run(reference_byte, live_byte, section_end);
			end
			if (out_valid && out_ready)
				check_hit();
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!quiet) begin
				out_ready <= 1'b0;
				repeat (pick_stall()) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout with %0d hits outstanding", expected_hits.size());
		$display("tb_byte_mismatch_run_detector_unit: FAIL");
		$finish;
	end

	task automatic send_pair(input logic [7:0] ref_b, input logic [7:0] live_b,
		input logic last);
		int unsigned gap;
		in_valid <= 1'b1;
		reference_byte <= ref_b;
		live_byte <= live_b;
		section_end <= last;
		do @(posedge clk); while (!in_ready);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Valid drops and the clock advances before the queue is checked, so the last word is predicted.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		wait_for_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_registers(input logic [63:0] base, input logic [31:0] offset,
		input logic [LIMIT_W-1:0] limit);
		write_reg(CFG_MODULE_BASE, base);
		write_reg(CFG_SECTION_OFFSET, {32'd0, offset});
		write_reg(CFG_HIT_LIMIT, {51'd0, limit});
	endtask

	task automatic test_byte_extremes();
		send_pair(8'h00, 8'hFF, 1'b0);
		send_pair(8'hFF, 8'h00, 1'b0);
		send_pair(8'h00, 8'h00, 1'b0);
		send_pair(8'hFF, 8'hFF, 1'b0);
		send_pair(8'hFF, 8'hFE, 1'b1);
		// An equal byte that ends the section still closes the open run.
		send_pair(8'h80, 8'h7F, 1'b0);
		send_pair(8'hAA, 8'hAA, 1'b1);
		send_pair(8'h12, 8'h12, 1'b1);
		send_pair(8'h01, 8'h02, 1'b1);
		wait_for_idle();
	endtask

	task automatic test_address_wrap();
		load_registers('1, 32'hFFFF_FFFF, HIT_LIMIT_RESET);
		send_pair(8'h33, 8'h33, 1'b0);
		send_pair(8'h00, 8'h01, 1'b1);
		send_pair(8'h7E, 8'h81, 1'b0);
		send_pair(8'hC3, 8'hC3, 1'b1);
		wait_for_idle();
	endtask

	task automatic test_registers_mid_run();
		load_registers(64'h0000_0001_0000_0000, 32'h0000_1000, HIT_LIMIT_RESET);
		send_pair(8'h10, 8'h20, 1'b0);
		send_pair(8'h30, 8'h40, 1'b0);
		load_registers(64'hFFFF_0000_0000_0000, 32'h8000_0000, HIT_LIMIT_RESET);
		send_pair(8'h50, 8'h60, 1'b0);
		send_pair(8'h70, 8'h70, 1'b1);
		wait_for_idle();
	endtask

	task automatic test_hit_limit();
		wait_for_idle();
		write_reg(CFG_HIT_LIMIT, 64'(hits_sent) + 64'd1);
		send_pair(8'h01, 8'h02, 1'b0);
		send_pair(8'h03, 8'h03, 1'b0);
		send_pair(8'h04, 8'h05, 1'b0);
		send_pair(8'h06, 8'h06, 1'b0);
		send_pair(8'h07, 8'h08, 1'b0);
		write_reg(CFG_HIT_LIMIT, 64'd0);
		send_pair(8'h09, 8'h0A, 1'b1);
		write_reg(CFG_HIT_LIMIT, {51'd0, {LIMIT_W{1'b1}}});
		send_pair(8'h0B, 8'h0C, 1'b0);
		send_pair(8'h0D, 8'h0E, 1'b1);
		wait_for_idle();
	endtask

	// Sections built from equal stretches, mismatch bursts and stretches of random noise.
	task automatic test_random_sections();
		int unsigned sent, len, k, seg_left, seg_kind;
		logic [7:0] a;
		logic [7:0] b;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: load_registers({$urandom, $urandom}, $urandom, HIT_LIMIT_RESET);
				1: load_registers('0, 32'hFFFF_FFFF, HIT_LIMIT_RESET);
				2: load_registers('1, $urandom, hits_sent + 13'd12);
				default: load_registers({$urandom, $urandom}, '0, {LIMIT_W{1'b1}});
			endcase
			quiet = (p == 1);
			sent = 0;
			seg_left = 0;
			seg_kind = 0;
			while (sent < RANDOM_PAIRS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) :
					$urandom_range(1, 30);
				if (len > RANDOM_PAIRS - sent)
					len = RANDOM_PAIRS - sent;
				for (k = 0; k < len; k++) begin
					if (seg_left == 0) begin
						seg_kind = $urandom_range(0, 19);
						if (seg_kind < 9)
							seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) :
								$urandom_range(1, 6);
						else
							seg_left = $urandom_range(1, 8);
					end
					seg_left--;
					a = $urandom;
					if (seg_kind < 9)
						b = a ^ 8'($urandom_range(1, 255));
					else if (seg_kind < 18)
						b = a;
					else
						b = $urandom;
					send_pair(a, b, k == len - 1);
					sent++;
				end
			end
			quiet = 1'b0;
		end
		wait_for_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		reference_byte = '0;
		live_byte = '0;
		section_end = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_byte_extremes();
		test_address_wrap();
		test_registers_mid_run();
		test_hit_limit();
		test_random_sections();
		$display("Streamed %0d byte pairs, checked %0d hits, made %0d register writes.",
			pairs_accepted, hits_checked, reg_writes);
		$display("Covered reset and extreme registers, address wrap, limit suppression and reuse.");
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("tb_byte_mismatch_run_detector_unit: PASS");
		else
			$display("tb_byte_mismatch_run_detector_unit: FAIL");
		$finish;
	end

endmodule
